>>> hw/rtl/log_odds_cell_update_assert.svh
// Assertion macros shared by the log-odds cell update RTL.
// Expects signals named clk and rst_n in the scope of use.
`ifndef LOG_ODDS_CELL_UPDATE_ASSERT_SVH
`define LOG_ODDS_CELL_UPDATE_ASSERT_SVH

// same-cycle implication
`define LOU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LOU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/lou_pkg.sv
// Types and constants of the log-odds cell update block.
// No dependencies.
`default_nettype none

package lou_pkg;

  typedef enum logic [1:0] {
    CLASS_UNEXPLORED = 2'd0,
    CLASS_FREE       = 2'd1,
    CLASS_OCCUPIED   = 2'd2
  } cell_class_t;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OCC_LGT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_LGT = 3'd4;

  localparam logic signed [15:0] STEP_RESET     = 16'sd560;
  localparam logic signed [15:0] MIN_RESET      = -16'sd512;
  localparam logic signed [15:0] MAX_RESET      = 16'sd512;
  localparam logic signed [15:0] OCC_LGT_RESET  = 16'sd256;
  localparam logic signed [15:0] FREE_LGT_RESET = -16'sd256;

  typedef struct packed {
    logic [7:0] cell_row;
    logic [7:0] cell_col;
    logic       observed_hit;
  } lou_in_t;

  typedef struct packed {
    logic signed [15:0] new_log_odd;
    cell_class_t        cell_class;
    logic               class_changed;
    logic [16:0]        unexplored_total;
    logic [16:0]        free_total;
    logic [16:0]        occupied_total;
  } lou_out_t;

  typedef struct packed {
    logic signed [15:0] log_odd_step;
    logic signed [15:0] clamp_lo;
    logic signed [15:0] clamp_hi;
    logic signed [15:0] occupied_logit;
    logic signed [15:0] free_logit;
  } lou_cfg_t;

  typedef struct packed {
    cell_class_t        cls;
    logic signed [15:0] log_odd;
  } lou_cell_t;

  typedef struct packed {
    logic [16:0] unexplored;
    logic [16:0] free;
    logic [16:0] occupied;
  } lou_counts_t;

  typedef struct packed {
    lou_cell_t   entry;
    logic        changed;
    lou_counts_t counts;
  } lou_upd_t;

endpackage

`default_nettype wire

>>> hw/rtl/log_odds_cell_update.sv
// Top level of the log-odds occupancy cell update block.
// Depends on lou_pkg, lou_cell_mem, lou_update and log_odds_cell_update_assert.svh.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one observed cell (row,
//   column, hit). Result channel out_valid/out_stall/out_data returns one
//   result per item, in order: the cell's new log-odds, its class, a changed
//   flag and the three class totals after the item.
//   Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data writes the step,
//   clamp and threshold registers; cfg_ready is always high. Write only
//   while no item is in flight.
//   An input transfer loads the update stage; the result register loads
//   as that stage advances. Throughput: one item per cycle unless out_stall
//   holds; the cell store is read on transfer and written back as the stage
//   advances, a write-to-read forward covers back-to-back items on one cell.
//   Reset: counts and registers reload at once; then a clear sweep writes
//   every store entry, one per cycle, 2**(row bits + column bits) entries
//   (65536 at the default map size), with in_stall held high.
//   While a result waits under out_stall, the result register holds, the update
//   stage holds its item, and in_stall rises once that stage is occupied.
`default_nettype none
`include "log_odds_cell_update_assert.svh"

module log_odds_cell_update #(
  parameter int MAP_ROWS = 256,
  parameter int MAP_COLS = 256
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  lou_pkg::lou_in_t                    in_data,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output lou_pkg::lou_out_t                   out_data,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [lou_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [15:0]                          cfg_data
);
  import lou_pkg::*;

  localparam int EFF_ROWS = (MAP_ROWS > 256) ? 256 : MAP_ROWS;
  localparam int EFF_COLS = (MAP_COLS > 256) ? 256 : MAP_COLS;
  localparam int ROW_W    = (EFF_ROWS > 1) ? $clog2(EFF_ROWS) : 1;
  localparam int COL_W    = (EFF_COLS > 1) ? $clog2(EFF_COLS) : 1;
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam logic [16:0] CELLS_17 = 17'(MAP_ROWS * MAP_COLS);

  // configuration
  lou_cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.log_odd_step   <= STEP_RESET;
      cfg_r.clamp_lo       <= MIN_RESET;
      cfg_r.clamp_hi       <= MAX_RESET;
      cfg_r.occupied_logit <= OCC_LGT_RESET;
      cfg_r.free_logit     <= FREE_LGT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STEP:     cfg_r.log_odd_step   <= cfg_data;
        CFG_MIN:      cfg_r.clamp_lo       <= cfg_data;
        CFG_MAX:      cfg_r.clamp_hi       <= cfg_data;
        CFG_OCC_LGT:  cfg_r.occupied_logit <= cfg_data;
        CFG_FREE_LGT: cfg_r.free_logit     <= cfg_data;
        default: ;
      endcase
    end
  end

  // clear sweep
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == {ADDR_W{1'b1}}) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // pipeline control
  logic              s1_valid_r;
  logic              s1_in_map_r;
  logic              s1_hit_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              out_valid_r;
  lou_out_t          out_data_r;
  logic              out_free;
  logic              s1_adv;
  logic              in_acc;
  logic              in_map;
  logic [ADDR_W-1:0] in_addr;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = clearing_r || (s1_valid_r && !s1_adv);
  assign in_acc   = in_valid && !in_stall;
  assign in_map   = (32'(in_data.cell_row) < MAP_ROWS) && (32'(in_data.cell_col) < MAP_COLS);
  assign in_addr  = {in_data.cell_row[ROW_W-1:0], in_data.cell_col[COL_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_in_map_r <= in_map;
      s1_hit_r    <= in_data.observed_hit;
      s1_addr_r   <= in_addr;
    end
  end

  // store and forwarding
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  lou_cell_t         mem_wdata;
  lou_cell_t         mem_rdata;
  logic              fwd_valid_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  lou_cell_t         fwd_data_r;
  lou_cell_t         old_cell;
  lou_upd_t          upd;
  lou_counts_t       counts_r;

  assign mem_we    = clearing_r || (s1_adv && s1_in_map_r);
  assign mem_waddr = clearing_r ? clr_addr_r : s1_addr_r;
  assign mem_wdata = clearing_r ? lou_cell_t'{cls: CLASS_UNEXPLORED, log_odd: '0} : upd.entry;

  lou_cell_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_acc),
    .raddr (in_addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (s1_adv && s1_in_map_r) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_in_map_r) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= upd.entry;
    end
  end

  assign old_cell = (fwd_valid_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : mem_rdata;

  lou_update u_update (
    .cfg      (cfg_r),
    .old_cell (old_cell),
    .counts   (counts_r),
    .hit      (s1_hit_r),
    .in_map   (s1_in_map_r),
    .upd      (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counts_r.unexplored <= CELLS_17;
      counts_r.free       <= '0;
      counts_r.occupied   <= '0;
    end else if (s1_adv) begin
      counts_r <= upd.counts;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.new_log_odd      <= upd.entry.log_odd;
      out_data_r.cell_class       <= upd.entry.cls;
      out_data_r.class_changed    <= upd.changed;
      out_data_r.unexplored_total <= upd.counts.unexplored;
      out_data_r.free_total       <= upd.counts.free;
      out_data_r.occupied_total   <= upd.counts.occupied;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LOU_ASSERT_NOW(a_cnt_total, 1'b1, (counts_r.unexplored + counts_r.free + counts_r.occupied) == CELLS_17, "class totals do not add up to the cell count")
  `LOU_ASSERT_NOW(a_chg_class, out_valid_r && out_data_r.class_changed, out_data_r.cell_class != CLASS_UNEXPLORED, "changed cell reported as unexplored")
  `LOU_ASSERT_NEXT(a_fwd_track, s1_adv && s1_in_map_r, fwd_valid_r && (fwd_addr_r == $past(s1_addr_r)), "forward register missed a write-back")
  `LOU_ASSERT_NOW(a_no_acc_clr, clearing_r, !s1_valid_r && !out_valid_r, "item in flight during clear sweep")

endmodule

`default_nettype wire

>>> hw/rtl/lou_cell_mem.sv
// Cell store: log-odds and class per cell, one write and one registered read port.
// Depends on lou_pkg.
`default_nettype none

module lou_cell_mem #(
  parameter int ADDR_W = 16
) (
  input  wire                    clk,
  input  wire                    we,
  input  wire [ADDR_W-1:0]       waddr,
  input  lou_pkg::lou_cell_t     wdata,
  input  wire                    re,
  input  wire [ADDR_W-1:0]       raddr,
  output lou_pkg::lou_cell_t     rdata
);
  import lou_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  lou_cell_t mem [DEPTH];
  lou_cell_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hw/rtl/lou_update.sv
// Cell update datapath: saturating add or subtract of the step, clamp, reclassify, count update.
// Depends on lou_pkg.
`default_nettype none

module lou_update (
  input  lou_pkg::lou_cfg_t    cfg,
  input  lou_pkg::lou_cell_t   old_cell,
  input  lou_pkg::lou_counts_t counts,
  input  wire                  hit,
  input  wire                  in_map,
  output lou_pkg::lou_upd_t    upd
);
  import lou_pkg::*;

  logic signed [17:0] old_x;
  logic signed [17:0] step_x;
  logic signed [17:0] sum;
  logic signed [15:0] sat;
  logic signed [15:0] clamped;
  cell_class_t        new_cls;
  logic               changed;
  lou_counts_t        cnt;

  always_comb begin
    old_x  = {{2{old_cell.log_odd[15]}}, old_cell.log_odd};
    step_x = {{2{cfg.log_odd_step[15]}}, cfg.log_odd_step};
    sum    = hit ? (old_x + step_x) : (old_x - step_x);

    if (sum[17:15] == 3'b000 || sum[17:15] == 3'b111) begin
      sat = sum[15:0];
    end else if (!sum[17]) begin
      sat = 16'sh7FFF;
    end else begin
      sat = 16'sh8000;
    end

    if (sat < cfg.clamp_lo) begin
      clamped = cfg.clamp_lo;
    end else if (sat > cfg.clamp_hi) begin
      clamped = cfg.clamp_hi;
    end else begin
      clamped = sat;
    end

    if (clamped > cfg.occupied_logit) begin
      new_cls = CLASS_OCCUPIED;
    end else if (clamped < cfg.free_logit) begin
      new_cls = CLASS_FREE;
    end else begin
      new_cls = old_cell.cls;
    end

    changed = in_map && (new_cls != old_cell.cls);

    cnt = counts;
    if (changed) begin
      case (old_cell.cls)
        CLASS_UNEXPLORED: cnt.unexplored = counts.unexplored - 17'd1;
        CLASS_FREE:       cnt.free       = counts.free - 17'd1;
        default:          cnt.occupied   = counts.occupied - 17'd1;
      endcase
      if (new_cls == CLASS_FREE) begin
        cnt.free = cnt.free + 17'd1;
      end else begin
        cnt.occupied = cnt.occupied + 17'd1;
      end
    end

    upd.changed = changed;
    upd.counts  = cnt;
    if (in_map) begin
      upd.entry.log_odd = clamped;
      upd.entry.cls     = new_cls;
    end else begin
      upd.entry.log_odd = '0;
      upd.entry.cls     = CLASS_UNEXPLORED;
    end
  end

endmodule

`default_nettype wire
